// File: rtl/ats_pkg.sv
package ats_pkg;

	localparam int NUM_STATES      = 16;
	localparam int NUM_TRANSITIONS = 32;
	localparam int NUM_GROUPS      = 8;
	localparam int NUM_DIRECTIONS  = 8;
	localparam int FRAME_BITS      = 8;

	localparam int STATE_W = 4;
	localparam int TIDX_W  = 5;
	localparam int DIR_W   = 8;
	localparam int GRP_W   = 8;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_TRANS = 2'd1,
		MODE_STATE = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ANY   = 2'd0,
		KIND_GROUP = 2'd1,
		KIND_STATE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [5:0]            pad;
		logic                  entry_valid;
		logic [GRP_W-1:0]      group_mask;
		logic                  has_next;
		logic [FRAME_BITS-1:0] frame_count;
		logic                  keep_frame;
		logic [STATE_W-1:0]    target_state;
		logic [STATE_W-1:0]    from_id;
		logic [1:0]            from_kind;
		logic [DIR_W-1:0]      directions;
		logic [TIDX_W-1:0]     entry_index;
	} in_data_t;

	typedef struct packed {
		logic [5:0]            pad;
		logic [TIDX_W-1:0]     match_index;
		logic                  matched;
		logic [FRAME_BITS-1:0] frame_pos;
		logic [STATE_W-1:0]    state_id;
	} out_data_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [STATE_W-1:0] src;
		logic [DIR_W-1:0]   dirs;
		logic [STATE_W-1:0] target;
		logic               keep;
	} trans_ent_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frames;
		logic                  has_next;
		logic [STATE_W-1:0]    next;
		logic [GRP_W-1:0]      groups;
	} state_ent_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [TIDX_W-1:0] waddr;
		logic [TIDX_W-1:0] raddr;
		logic              wvalid;
		trans_ent_t        wdata;
	} ttab_req_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [STATE_W-1:0] waddr;
		logic [STATE_W-1:0] raddr;
		logic               wvalid;
		state_ent_t         wdata;
	} stab_req_t;

endpackage

// File: rtl/ats_ttab.sv
module ats_ttab import ats_pkg::*; #(
	parameter int NUM_TRANS = NUM_TRANSITIONS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ttab_req_t  req,
	output logic       rd_valid,
	output trans_ent_t rd_ent
);

	localparam int AW = (NUM_TRANS > 1) ? $clog2(NUM_TRANS) : 1;

	trans_ent_t             mem_q [NUM_TRANS];
	logic [NUM_TRANS-1:0]   valid_q;
	logic                   rd_valid_q;
	trans_ent_t             rd_ent_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_ent_q <= mem_q[req.raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr[AW-1:0]] <= req.wvalid;
			end
			if (req.re) begin
				rd_valid_q <= valid_q[req.raddr[AW-1:0]];
			end
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_ent   = rd_ent_q;

endmodule

// File: rtl/ats_stab.sv
module ats_stab import ats_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stab_req_t  req,
	output logic       rd_valid,
	output state_ent_t rd_ent
);

	state_ent_t            mem_q [NUM_STATES];
	logic [NUM_STATES-1:0] valid_q;
	logic                  rd_valid_q;
	state_ent_t            rd_ent_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_ent_q <= mem_q[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= req.wvalid;
			end
			if (req.re) begin
				rd_valid_q <= valid_q[req.raddr];
			end
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_ent   = rd_ent_q;

endmodule

// File: rtl/ats_ctrl.sv
module ats_ctrl import ats_pkg::*; #(
	parameter int NUM_TRANS = NUM_TRANSITIONS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,
	input  logic               cfg_we,
	input  logic [STATE_W-1:0] cfg_wdata,
	output ttab_req_t          ttab_req,
	input  logic               ttab_valid,
	input  trans_ent_t         ttab_ent,
	output stab_req_t          stab_req,
	input  logic               stab_valid,
	input  state_ent_t         stab_ent
);

	localparam int AW = (NUM_TRANS > 1) ? $clog2(NUM_TRANS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CUR  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_DONE = 5'b10000
	} fsm_t;

	fsm_t                  st_q;
	in_data_t              din;
	mode_t                 mode;
	logic                  accept;
	logic [STATE_W-1:0]    dflt_q;
	logic [STATE_W-1:0]    cur_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [DIR_W-1:0]      dirs_q;
	logic [AW-1:0]         cnt_q;
	logic                  matched_q;
	logic [AW-1:0]         hit_idx_q;
	logic [STATE_W-1:0]    hit_tgt_q;
	logic                  hit_keep_q;
	logic                  m_tvalid_q;
	out_data_t             m_data_q;
	logic                  src_ok;
	logic                  hit;
	logic                  last;
	state_ent_t            se;
	logic [FRAME_BITS:0]   adv;
	logic                  at_end;
	logic [STATE_W-1:0]    nxt_state;
	logic [FRAME_BITS-1:0] nxt_frame;
	logic                  out_free;

	assign din    = in_data_t'(s_tdata);
	assign mode   = mode_t'(s_tuser);
	assign s_tready = (st_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		ttab_req              = '0;
		ttab_req.we           = accept && (mode == MODE_TRANS)
			&& (int'(din.entry_index) < NUM_TRANS);
		ttab_req.waddr        = din.entry_index;
		ttab_req.wvalid       = din.entry_valid;
		ttab_req.wdata.kind   = din.from_kind;
		ttab_req.wdata.src    = din.from_id;
		ttab_req.wdata.dirs   = din.directions;
		ttab_req.wdata.target = din.target_state;
		ttab_req.wdata.keep   = din.keep_frame;
		ttab_req.re           = (st_q == ST_CUR) || (st_q == ST_SCAN);
		ttab_req.raddr        = (st_q == ST_CUR) ? '0 : TIDX_W'(cnt_q + AW'(1));

		stab_req                = '0;
		stab_req.we             = accept && (mode == MODE_STATE)
			&& (int'(din.entry_index) < NUM_STATES);
		stab_req.waddr          = din.entry_index[STATE_W-1:0];
		stab_req.wvalid         = din.entry_valid;
		stab_req.wdata.frames   = din.frame_count;
		stab_req.wdata.has_next = din.has_next;
		stab_req.wdata.next     = din.target_state;
		stab_req.wdata.groups   = din.group_mask;
		stab_req.re             = (st_q == ST_CUR) || ((st_q == ST_SCAN) && hit);
		stab_req.raddr          = (st_q == ST_CUR) ? cur_q : ttab_ent.target;
	end

	always_comb begin
		case (kind_t'(ttab_ent.kind))
			KIND_ANY:   src_ok = 1'b1;
			KIND_GROUP: src_ok = (int'(ttab_ent.src) < NUM_GROUPS) && stab_valid
				&& stab_ent.groups[ttab_ent.src[2:0]];
			KIND_STATE: src_ok = (ttab_ent.src == cur_q);
			default:    src_ok = 1'b0;
		endcase
	end

	assign hit  = ttab_valid && src_ok && (|(ttab_ent.dirs & dirs_q));
	assign last = (cnt_q == AW'(NUM_TRANS - 1));

	// shared frame advance and end-of-sequence compare
	assign se     = stab_valid ? stab_ent : '0;
	assign adv    = {1'b0, frame_q} + (FRAME_BITS+1)'(1);
	assign at_end = (adv >= {1'b0, se.frames});

	always_comb begin
		nxt_state = cur_q;
		nxt_frame = '0;
		if (matched_q) begin
			if (stab_valid) begin
				nxt_state = hit_tgt_q;
				nxt_frame = (hit_keep_q && !at_end) ? adv[FRAME_BITS-1:0] : '0;
			end else begin
				nxt_state = dflt_q;
			end
		end else if (at_end) begin
			nxt_state = se.has_next ? se.next : dflt_q;
		end else begin
			nxt_frame = adv[FRAME_BITS-1:0];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			dflt_q     <= '0;
			cur_q      <= '0;
			frame_q    <= '0;
			matched_q  <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
			end
			if ((st_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						matched_q <= 1'b0;
						st_q      <= (mode == MODE_TICK) ? ST_CUR : ST_DONE;
					end
				end
				ST_CUR: begin
					cnt_q <= '0;
					st_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit) begin
						matched_q <= 1'b1;
						st_q      <= ST_UPD;
					end else if (last) begin
						st_q <= ST_UPD;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_UPD: begin
					cur_q   <= nxt_state;
					frame_q <= nxt_frame;
					st_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dirs_q <= din.directions;
		end
		if ((st_q == ST_SCAN) && hit) begin
			hit_idx_q  <= cnt_q;
			hit_tgt_q  <= ttab_ent.target;
			hit_keep_q <= ttab_ent.keep;
		end
		if ((st_q == ST_DONE) && out_free) begin
			m_data_q.pad         <= '0;
			m_data_q.state_id    <= cur_q;
			m_data_q.frame_pos   <= frame_q;
			m_data_q.matched     <= matched_q;
			m_data_q.match_index <= matched_q ? TIDX_W'(hit_idx_q) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: rtl/animation_transition_sequencer_top.sv
// channel   dir  signals                       contents
// s_        in   s_tvalid s_tready s_tdata     request: table write or tick
//                s_tuser                       mode
// m_        out  m_tvalid m_tready m_tdata     state, frame and match after request
// cfg_      in   cfg_we cfg_wdata              default state
//
// A table write goes from acceptance straight to ST_DONE; a tick passes ST_CUR,
// ST_SCAN and ST_UPD first, its scan reading one transition entry a cycle
// through the table's single read port and stopping at the first hit.
// Reset clears both tables to invalid at once, with no clearing pass.
// A result held by m_tready low keeps the block from finishing the next request.
module animation_transition_sequencer_top import ats_pkg::*; #(
	parameter int NUM_TRANS = NUM_TRANSITIONS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// entry_index, directions, from_kind, from_id, target_state, keep_frame,
	// frame_count, has_next, group_mask, entry_valid, zero fill
	input  logic [47:0]        s_tdata,
	// mode
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// state_id, frame_pos, matched, match_index, zero fill
	output logic [23:0]        m_tdata,
	input  logic               cfg_we,
	input  logic [STATE_W-1:0] cfg_wdata
);

	ttab_req_t  ttab_req;
	logic       ttab_valid;
	trans_ent_t ttab_ent;
	stab_req_t  stab_req;
	logic       stab_valid;
	state_ent_t stab_ent;

	ats_ttab #(
		.NUM_TRANS(NUM_TRANS)
	) u_ttab (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ttab_req),
		.rd_valid(ttab_valid),
		.rd_ent  (ttab_ent)
	);

	ats_stab u_stab (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (stab_req),
		.rd_valid(stab_valid),
		.rd_ent  (stab_ent)
	);

	ats_ctrl #(
		.NUM_TRANS(NUM_TRANS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ttab_req  (ttab_req),
		.ttab_valid(ttab_valid),
		.ttab_ent  (ttab_ent),
		.stab_req  (stab_req),
		.stab_valid(stab_valid),
		.stab_ent  (stab_ent)
	);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ats_pkg::*;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [3:0] src;
		logic [7:0] dirs;
		logic [3:0] target;
		logic       keep;
	} route_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] frames;
		logic       has_follow;
		logic [3:0] follow;
		logic [7:0] groups;
	} clip_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;

	route_t      route_tab [NUM_TRANSITIONS];
	clip_t       clip_tab [NUM_STATES];
	logic [3:0]  cur_state;
	logic [7:0]  cur_frame;
	logic [3:0]  dflt_state;

	out_data_t   expected_pose_q [$];
	out_data_t   got_pose;
	out_data_t   want_pose;
	int          n_fail;
	int          n_results;
	bit          src_idle_on;
	bit          sink_idle_on;
	int          sink_hold_left;

	animation_transition_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_data_t step_sequencer(input mode_t m, input in_data_t d);
		clip_t      here;
		clip_t      dest;
		route_t     r;
		logic [8:0] adv;
		logic       hit;
		logic       src_ok;
		logic [4:0] hit_idx;
		out_data_t  res;
		hit = 1'b0;
		hit_idx = '0;
		case (m)
		MODE_TRANS: begin
			r = '0;
			if (d.entry_valid) begin
				r.valid = 1'b1;
				r.kind = d.from_kind;
				r.src = d.from_id;
				r.dirs = d.directions;
				r.target = d.target_state;
				r.keep = d.keep_frame;
			end
			route_tab[d.entry_index] = r;
		end
		MODE_STATE: begin
			if (d.entry_index < NUM_STATES) begin
				dest = '0;
				if (d.entry_valid) begin
					dest.valid = 1'b1;
					dest.frames = d.frame_count;
					dest.has_follow = d.has_next;
					dest.follow = d.target_state;
					dest.groups = d.group_mask;
				end
				clip_tab[d.entry_index[3:0]] = dest;
			end
		end
		MODE_TICK: begin
			here = clip_tab[cur_state].valid ? clip_tab[cur_state] : '0;
			adv = {1'b0, cur_frame} + 9'd1;
			for (int i = 0; i < NUM_TRANSITIONS; i++) begin
				r = route_tab[i];
				case (r.kind)
				KIND_ANY:   src_ok = 1'b1;
				KIND_GROUP: src_ok = (r.src < NUM_GROUPS) && here.groups[r.src[2:0]];
				KIND_STATE: src_ok = (r.src == cur_state);
				default:    src_ok = 1'b0;
				endcase
				if (!hit && r.valid && src_ok && ((r.dirs & d.directions) != 0)) begin
					hit = 1'b1;
					hit_idx = i[4:0];
				end
			end
			if (hit) begin
				r = route_tab[hit_idx];
				dest = clip_tab[r.target];
				if (dest.valid) begin
					cur_state = r.target;
					if (r.keep && adv < {1'b0, dest.frames})
						cur_frame = adv[7:0];
					else
						cur_frame = '0;
				end else begin
					cur_state = dflt_state;
					cur_frame = '0;
				end
			end else if (adv >= {1'b0, here.frames}) begin
				cur_state = here.has_follow ? here.follow : dflt_state;
				cur_frame = '0;
			end else begin
				cur_frame = adv[7:0];
			end
		end
		default: begin
		end
		endcase
		res = '0;
		res.state_id = cur_state;
		res.frame_pos = cur_frame;
		res.matched = hit;
		res.match_index = hit_idx;
		return res;
	endfunction

	function automatic in_data_t route_req(input int idx, input kind_t k, input int src,
			input int dirs, input int target, input bit keep, input bit valid);
		in_data_t d;
		d = '0;
		d.entry_index = idx[4:0];
		d.from_kind = k;
		d.from_id = src[3:0];
		d.directions = dirs[7:0];
		d.target_state = target[3:0];
		d.keep_frame = keep;
		d.entry_valid = valid;
		return d;
	endfunction

	function automatic in_data_t clip_req(input int idx, input int frames, input bit has_follow,
			input int follow, input int groups, input bit valid);
		in_data_t d;
		d = '0;
		d.entry_index = idx[4:0];
		d.frame_count = frames[7:0];
		d.has_next = has_follow;
		d.target_state = follow[3:0];
		d.group_mask = groups[7:0];
		d.entry_valid = valid;
		return d;
	endfunction

	function automatic in_data_t tick_req(input int dirs);
		in_data_t d;
		d = '0;
		d.directions = dirs[7:0];
		return d;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		n_fail++;
		if (n_fail <= 40)
			$display("%0t: result %0d %s: got %0d, expected %0d",
				$time, n_results, what, got_v, want_v);
	endtask

	task automatic send_request(input mode_t m, input in_data_t d);
		int gap;
		gap = 0;
		if (src_idle_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 17);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= m;
		do @(posedge clk); while (!s_tready);
		expected_pose_q = {expected_pose_q, step_sequencer(m, d)};
	endtask

	task automatic make_request(output mode_t m, output in_data_t d);
		int pick;
		d = in_data_t'({$urandom, $urandom});
		d.pad = '0;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			m = MODE_TICK;
			pick = $urandom_range(0, 9);
			if (pick < 3)
				d.directions = 8'd1 << $urandom_range(0, 7);
			else if (pick == 3)
				d.directions = '0;
		end else if (pick < 72) begin
			m = MODE_TRANS;
			d.entry_valid = ($urandom_range(0, 6) != 0);
			pick = $urandom_range(0, 19);
			if (pick < 4)
				d.from_kind = KIND_ANY;
			else if (pick < 11)
				d.from_kind = KIND_GROUP;
			else if (pick < 18)
				d.from_kind = KIND_STATE;
			else
				d.from_kind = KIND_NONE;
			if (d.from_kind == KIND_GROUP && $urandom_range(0, 4) != 0)
				d.from_id = 4'($urandom_range(0, NUM_GROUPS - 1));
			if ($urandom_range(0, 1) == 0)
				d.directions = 8'd1 << $urandom_range(0, 7);
		end else if (pick < 95) begin
			m = MODE_STATE;
			if ($urandom_range(0, 6) != 0)
				d.entry_index = 5'($urandom_range(0, NUM_STATES - 1));
			d.entry_valid = ($urandom_range(0, 9) != 0);
			pick = $urandom_range(0, 19);
			if (pick < 15)
				d.frame_count = 8'($urandom_range(1, 6));
			else if (pick < 17)
				d.frame_count = '0;
		end else begin
			m = MODE_NONE;
		end
	endtask

	task automatic write_default(input int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[3:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		dflt_state = v[3:0];
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (expected_pose_q.size() == 0);
	endtask

	task automatic run_random(input int n_items);
		mode_t    m;
		in_data_t d;
		repeat (n_items) begin
			make_request(m, d);
			send_request(m, d);
		end
	endtask

	task automatic test_directed_cases();
		write_default(15);
		send_request(MODE_TICK, tick_req(8'h00));
		send_request(MODE_NONE, in_data_t'({6'd0, {42{1'b1}}}));
		send_request(MODE_STATE, clip_req(20, 3, 1, 1, 8'hff, 1));
		send_request(MODE_STATE, clip_req(15, 255, 1, 3, 8'h80, 1));
		send_request(MODE_STATE, clip_req(0, 2, 0, 0, 8'h01, 1));
		send_request(MODE_STATE, clip_req(1, 0, 1, 15, 8'h00, 1));
		send_request(MODE_TRANS, route_req(0, KIND_NONE, 0, 8'hff, 0, 1, 1));
		send_request(MODE_TRANS, route_req(1, KIND_GROUP, 9, 8'hff, 0, 1, 1));
		send_request(MODE_TRANS, route_req(2, KIND_GROUP, 7, 8'h80, 0, 1, 1));
		send_request(MODE_TRANS, route_req(31, KIND_STATE, 0, 8'h01, 12, 0, 1));
		send_request(MODE_TICK, tick_req(8'h80));
		send_request(MODE_TICK, tick_req(8'h01));
		send_request(MODE_TICK, tick_req(8'h00));
		send_request(MODE_STATE, clip_req(15, 1, 1, 3, 8'h80, 1));
		send_request(MODE_TICK, tick_req(8'h00));
		send_request(MODE_TICK, tick_req(8'h00));
		send_request(MODE_TRANS, route_req(3, KIND_ANY, 0, 8'h40, 15, 0, 1));
		send_request(MODE_TICK, tick_req(8'h40));
		send_request(MODE_TRANS, route_req(3, KIND_ANY, 0, 8'h40, 15, 0, 0));
		send_request(MODE_TICK, tick_req(8'hff));
		send_request(MODE_STATE, clip_req(0, 2, 0, 0, 8'h01, 0));
		send_request(MODE_TICK, tick_req(8'h00));
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int n_items, input int dflt);
		write_default(dflt);
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		run_random(n_items);
		wait_for_results();
	endtask

	task automatic test_backpressure_fill();
		sink_hold_left = 300;
		run_random(16);
		wait_for_results();
	endtask

	task automatic test_pause_until_drained();
		repeat (3) begin
			run_random(10);
			wait_for_results();
		end
		write_default(9);
		run_random(10);
		wait_for_results();
	endtask

	task automatic test_steady_stream(input int n_items);
		write_default(15);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		run_random(n_items);
		wait_for_results();
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_left > 0) begin
				sink_hold_left--;
				m_tready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
				sink_hold_left = $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_pose = m_tdata;
			n_results++;
			if (expected_pose_q.size() == 0) begin
				report_mismatch("unexpected, state_id", got_pose.state_id, 0);
			end else begin
				want_pose = expected_pose_q.pop_front();
				if (got_pose.state_id !== want_pose.state_id)
					report_mismatch("state_id", got_pose.state_id, want_pose.state_id);
				if (got_pose.frame_pos !== want_pose.frame_pos)
					report_mismatch("frame", got_pose.frame_pos,
						want_pose.frame_pos);
				if (got_pose.matched !== want_pose.matched)
					report_mismatch("matched", got_pose.matched, want_pose.matched);
				if (got_pose.match_index !== want_pose.match_index)
					report_mismatch("match_index", got_pose.match_index,
						want_pose.match_index);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("** animation_transition_sequencer_top: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_TICK;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		n_fail = 0;
		n_results = 0;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		sink_hold_left = 0;
		cur_state = '0;
		cur_frame = '0;
		dflt_state = '0;
		foreach (route_tab[i])
			route_tab[i] = '0;
		foreach (clip_tab[i])
			clip_tab[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_traffic(450, 7);
		test_random_traffic(350, 0);
		test_backpressure_fill();
		test_pause_until_drained();
		test_steady_stream(380);

		repeat (40) @(posedge clk);
		if (n_fail == 0)
			$display("** animation_transition_sequencer_top: PASSED **");
		else
			$display("** animation_transition_sequencer_top: FAILED **");
		$finish;
	end

endmodule

// File: animation_transition_sequencer_top.f
rtl/ats_pkg.sv
rtl/ats_ttab.sv
rtl/ats_stab.sv
rtl/ats_ctrl.sv
rtl/animation_transition_sequencer_top.sv
bench/tb_top.sv
